@@ src/dtfs_pkg.sv @@
// ----------------------------------------------------------------------------
// dtfs_pkg
// shared types, constants and separator match helpers for the field splitter
// ----------------------------------------------------------------------------
package dtfs_pkg;

  localparam int DelimMax   = 8;
  localparam int MaxColumns = 1600;
  localparam int HoldDepth  = 8;
  localparam int MaxResults = 10;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam logic [1:0] EOL_LF   = 2'd0;
  localparam logic [1:0] EOL_CR   = 2'd1;
  localparam logic [1:0] EOL_CRLF = 2'd2;

  localparam logic [1:0] MATCH_NONE   = 2'd0;
  localparam logic [1:0] MATCH_PREFIX = 2'd1;
  localparam logic [1:0] MATCH_FULL   = 2'd2;

  localparam logic [2:0] CFG_DELIM_BYTES   = 3'd0;
  localparam logic [2:0] CFG_DELIM_LEN     = 3'd1;
  localparam logic [2:0] CFG_EOL_MODE      = 3'd2;
  localparam logic [2:0] CFG_QUOTE_ENABLE  = 3'd3;
  localparam logic [2:0] CFG_QUOTE_CHAR    = 3'd4;
  localparam logic [2:0] CFG_ESCAPE_ENABLE = 3'd5;
  localparam logic [2:0] CFG_ESCAPE_CHAR   = 3'd6;
  localparam logic [2:0] CFG_COLUMN_COUNT  = 3'd7;

  typedef enum logic [1:0] {PH_START, PH_DATA, PH_CLOSE, PH_SKIP} phase_t;

  typedef enum logic [2:0] {
    ERR_NONE, ERR_TOO_MANY, ERR_TOO_FEW, ERR_NO_QUOTE, ERR_BARE_QUOTE, ERR_TRUNCATED
  } err_t;

  typedef struct packed {
    logic [63:0] delim_bytes;
    logic [3:0]  delim_len;
    logic [1:0]  eol_mode;
    logic        quote_enable;
    logic [7:0]  quote_char;
    logic        escape_enable;
    logic [7:0]  escape_char;
    logic [10:0] column_count;
  } cfg_t;

  typedef struct packed {
    phase_t                        phase;
    logic                          esc_par;
    logic [HoldDepth-1:0][7:0]     held;
    logic [3:0]                    held_cnt;
    logic [10:0]                   col;
    logic                          has_data;
  } state_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        field_end;
    logic        field_null;
    logic [10:0] field_index;
    logic        row_end;
    err_t        error_code;
  } res_t;

  function automatic logic [3:0] dlen(cfg_t c);
    logic [3:0] n;
    n = c.delim_len;
    if (n == 4'd0) n = 4'd1;
    if (n > 4'(DelimMax)) n = 4'(DelimMax);
    return n;
  endfunction

  function automatic logic [3:0] elen(cfg_t c);
    return (c.eol_mode == EOL_CRLF) ? 4'd2 : 4'd1;
  endfunction

  function automatic logic [10:0] ncols(cfg_t c);
    logic [10:0] n;
    n = c.column_count;
    if (n == 11'd0) n = 11'd1;
    if (n > 11'(MaxColumns)) n = 11'(MaxColumns);
    return n;
  endfunction

  function automatic logic [7:0] sep_byte(cfg_t c, logic delim, logic [2:0] i);
    logic [7:0] b;
    if (delim) begin
      b = c.delim_bytes[{i, 3'b000} +: 8];
    end else if (c.eol_mode == EOL_CR) begin
      b = CHAR_CR;
    end else if (c.eol_mode == EOL_CRLF) begin
      b = (i == 3'd0) ? CHAR_CR : CHAR_LF;
    end else begin
      b = CHAR_LF;
    end
    return b;
  endfunction

  // full separator at head, proper prefix, or no match
  function automatic logic [1:0] head_match(cfg_t c, logic delim, state_t s);
    logic [3:0] n;
    logic       mis;
    n   = delim ? dlen(c) : elen(c);
    mis = 1'b0;
    for (int i = 0; i < HoldDepth; i++) begin
      if (4'(i) < n && 4'(i) < s.held_cnt && s.held[i] != sep_byte(c, delim, 3'(i)))
        mis = 1'b1;
    end
    if (mis) return MATCH_NONE;
    return (s.held_cnt >= n) ? MATCH_FULL : MATCH_PREFIX;
  endfunction

  // pending bytes could still grow into a separator: wait for more input
  function automatic logic must_wait(cfg_t c, state_t s);
    logic [1:0] me;
    logic [1:0] md;
    logic       esc_hit;
    logic       w;
    me      = head_match(c, 1'b0, s);
    md      = head_match(c, 1'b1, s);
    esc_hit = c.escape_enable && s.held[0] == c.escape_char;
    w       = 1'b0;
    if (s.held_cnt != 4'd0) begin
      if (s.phase == PH_SKIP) begin
        w = (me == MATCH_PREFIX);
      end else if (!c.quote_enable) begin
        w = !esc_hit && me != MATCH_FULL && (me == MATCH_PREFIX || md == MATCH_PREFIX);
      end else if (s.phase == PH_CLOSE) begin
        w = me != MATCH_FULL && (me == MATCH_PREFIX || md == MATCH_PREFIX);
      end
    end
    return w;
  endfunction

endpackage

@@ src/delimited_text_field_splitter.sv @@
// ----------------------------------------------------------------------------
// delimited_text_field_splitter
// splits a byte stream into rows and fields with escape and quote handling
// ----------------------------------------------------------------------------
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------
//   input    | in_valid / in_ready   | in_byte, end_of_input
//   output   | out_valid / out_ready | out_byte, byte_valid, field_end,
//            |                       | field_null, field_index, row_end,
//            |                       | error_code, last_result
//   config   | cfg_we                | cfg_index, cfg_data
//
// one parse decision per cycle unless the engine holds; plain text streams at
// one byte per cycle, and each further decision (held separator bytes released,
// a lone escape, a quote fault) is taken before the next byte is accepted
// an escaped separator is replayed as plain data, one result per separator byte;
// an end-of-input byte flushes the pending bytes, then closes a truncated row
// results leave through a two-entry output queue; the engine holds only when
// the last result of the byte in flight has nowhere to go
// reset is synchronous; config returns to its defaults, no clearing pass
//
module delimited_text_field_splitter (
  input  logic        clk,
  input  logic        rst,
  // config writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        field_end,
  output logic        field_null,
  output logic [10:0] field_index,
  output logic        row_end,
  output logic [2:0]  error_code,
  output logic        last_result
);

  typedef enum logic [1:0] {M_RUN, M_SEQ, M_FIN} mode_t;

  typedef struct packed {
    dtfs_pkg::res_t res;
    logic           last;
  } qent_t;

  dtfs_pkg::cfg_t   cfg;
  dtfs_pkg::state_t st;
  mode_t            mode;
  logic             seq_delim;
  logic [2:0]       seq_i;
  logic             step_act;
  logic             step_eoi;
  logic             fin_act;
  logic [3:0]       res_n;
  logic             pend_v;
  dtfs_pkg::res_t   pend;
  qent_t            q [2];
  logic             q_rd;
  logic             q_wr;
  logic [1:0]       q_cnt;

  // combinational
  logic             brk_now;
  logic             stop;
  dtfs_pkg::state_t st_fix;
  dtfs_pkg::state_t view;
  logic [3:0]       app_cnt;
  dtfs_pkg::state_t nxt;
  logic             s_emit;
  dtfs_pkg::res_t   s_res;
  logic             s_seq_go;
  logic             s_seq_delim;
  logic             adv;
  logic             accept;
  logic             pop;

  // a pending-result hold slot lets last_result be set once the byte is done
  assign adv      = !pend_v || q_cnt != 2'd2;
  assign brk_now  = dtfs_pkg::must_wait(cfg, st);
  // pending bytes are only resolved inside a transfer
  assign stop     = !step_act || (st.held_cnt == 4'd0) || brk_now;
  assign in_ready = adv && mode == M_RUN && stop && !(step_act && step_eoi);
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_comb begin
    st_fix = st;
    // a wait on a partial separator still marks the row as begun
    if (brk_now && !cfg.quote_enable && st.phase != dtfs_pkg::PH_SKIP)
      st_fix.phase = dtfs_pkg::PH_DATA;
    view    = st_fix;
    app_cnt = st_fix.held_cnt;
    if (stop) begin
      if (app_cnt >= 4'(dtfs_pkg::HoldDepth)) begin
        for (int i = 0; i < dtfs_pkg::HoldDepth - 1; i++)
          view.held[i] = st_fix.held[i + 1];
        app_cnt = app_cnt - 4'd1;
      end
      view.held[app_cnt[2:0]] = in_byte;
      view.held_cnt           = app_cnt + 4'd1;
    end
  end

  dtfs_step u_step (
    .cfg       (cfg),
    .st        (view),
    .nxt       (nxt),
    .emit      (s_emit),
    .res       (s_res),
    .seq_go    (s_seq_go),
    .seq_delim (s_seq_delim)
  );

  // output queue head
  assign out_valid   = q_cnt != 2'd0;
  assign out_byte    = q[q_rd].res.out_byte;
  assign byte_valid  = q[q_rd].res.byte_valid;
  assign field_end   = q[q_rd].res.field_end;
  assign field_null  = q[q_rd].res.field_null;
  assign field_index = q[q_rd].res.field_index;
  assign row_end     = q[q_rd].res.row_end;
  assign error_code  = q[q_rd].res.error_code;
  assign last_result = q[q_rd].last;

  always_ff @(posedge clk) begin
    logic           new_emit;
    dtfs_pkg::res_t new_res;
    logic           end_step;
    logic [3:0]     res_base;
    logic           emit_ok;
    logic           push;
    qent_t          push_ent;
    logic           fin_data;

    new_emit = 1'b0;
    new_res  = '0;
    end_step = 1'b0;
    push     = 1'b0;
    push_ent = '0;
    res_base = res_n;
    fin_data = st.phase != dtfs_pkg::PH_SKIP && !cfg.quote_enable;

    if (rst) begin
      cfg.delim_bytes   <= 64'd44;
      cfg.delim_len     <= 4'd1;
      cfg.eol_mode      <= dtfs_pkg::EOL_LF;
      cfg.quote_enable  <= 1'b0;
      cfg.quote_char    <= 8'd34;
      cfg.escape_enable <= 1'b0;
      cfg.escape_char   <= 8'd92;
      cfg.column_count  <= 11'd1;
      st.phase          <= dtfs_pkg::PH_START;
      st.esc_par        <= 1'b0;
      st.held_cnt       <= 4'd0;
      st.col            <= 11'd0;
      st.has_data       <= 1'b0;
      mode              <= M_RUN;
      step_act          <= 1'b0;
      step_eoi          <= 1'b0;
      fin_act           <= 1'b0;
      res_n             <= 4'd0;
      pend_v            <= 1'b0;
      q_rd              <= 1'b0;
      q_wr              <= 1'b0;
      q_cnt             <= 2'd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          dtfs_pkg::CFG_DELIM_BYTES:   cfg.delim_bytes   <= cfg_data;
          dtfs_pkg::CFG_DELIM_LEN:     cfg.delim_len     <= cfg_data[3:0];
          dtfs_pkg::CFG_EOL_MODE:      cfg.eol_mode      <= cfg_data[1:0];
          dtfs_pkg::CFG_QUOTE_ENABLE:  cfg.quote_enable  <= cfg_data[0];
          dtfs_pkg::CFG_QUOTE_CHAR:    cfg.quote_char    <= cfg_data[7:0];
          dtfs_pkg::CFG_ESCAPE_ENABLE: cfg.escape_enable <= cfg_data[0];
          dtfs_pkg::CFG_ESCAPE_CHAR:   cfg.escape_char   <= cfg_data[7:0];
          dtfs_pkg::CFG_COLUMN_COUNT:  cfg.column_count  <= cfg_data[10:0];
          default: ;
        endcase
      end

      if (adv) begin
        unique case (mode)
          M_RUN: begin
            if (!stop) begin
              // keep resolving the pending bytes of this transfer
              st       <= nxt;
              new_emit = s_emit;
              new_res  = s_res;
              if (s_seq_go) begin
                mode      <= M_SEQ;
                seq_i     <= 3'd0;
                seq_delim <= s_seq_delim;
              end
            end else if (step_act && step_eoi) begin
              // end of stream: flush what is pending, then close the row
              st      <= st_fix;
              mode    <= M_FIN;
              fin_act <= st_fix.phase != dtfs_pkg::PH_START || st_fix.col != 11'd0 ||
                         st_fix.held_cnt != 4'd0 || st_fix.esc_par || st_fix.has_data;
            end else begin
              end_step = step_act;
              step_act <= accept;
              if (accept) begin
                res_base = 4'd0;
                st       <= nxt;
                step_eoi <= end_of_input;
                new_emit = s_emit;
                new_res  = s_res;
                if (s_seq_go) begin
                  mode      <= M_SEQ;
                  seq_i     <= 3'd0;
                  seq_delim <= s_seq_delim;
                end
              end else begin
                st <= st_fix;
              end
            end
          end
          M_SEQ: begin
            // escaped separator goes out as plain data bytes
            new_emit            = 1'b1;
            new_res.out_byte    = dtfs_pkg::sep_byte(cfg, seq_delim, seq_i);
            new_res.byte_valid  = 1'b1;
            new_res.field_index = st.col;
            st.has_data         <= 1'b1;
            seq_i               <= seq_i + 3'd1;
            if ({1'b0, seq_i} + 4'd1 ==
                (seq_delim ? dtfs_pkg::dlen(cfg) : dtfs_pkg::elen(cfg)))
              mode <= M_RUN;
          end
          M_FIN: begin
            if (fin_data && st.esc_par) begin
              new_emit            = 1'b1;
              new_res.out_byte    = cfg.escape_char;
              new_res.byte_valid  = 1'b1;
              new_res.field_index = st.col;
              st.esc_par          <= 1'b0;
              st.has_data         <= 1'b1;
            end else if (fin_data && st.held_cnt != 4'd0) begin
              new_emit            = 1'b1;
              new_res.out_byte    = st.held[0];
              new_res.byte_valid  = 1'b1;
              new_res.field_index = st.col;
              st.has_data         <= 1'b1;
              for (int i = 0; i < dtfs_pkg::HoldDepth - 1; i++)
                st.held[i] <= st.held[i + 1];
              st.held_cnt <= st.held_cnt - 4'd1;
            end else if (fin_act) begin
              // truncated row
              new_emit            = 1'b1;
              new_res.field_end   = 1'b1;
              new_res.field_null  = !st.has_data;
              new_res.row_end     = 1'b1;
              new_res.field_index = st.col;
              new_res.error_code  = dtfs_pkg::ERR_TRUNCATED;
              fin_act             <= 1'b0;
            end else begin
              st.held_cnt <= 4'd0;
              st.col      <= 11'd0;
              st.phase    <= dtfs_pkg::PH_START;
              st.esc_par  <= 1'b0;
              st.has_data <= 1'b0;
              mode        <= M_RUN;
              step_act    <= 1'b0;
              end_step    = 1'b1;
            end
          end
          default: mode <= M_RUN;
        endcase
      end

      // results past the per-transfer limit are dropped
      emit_ok = new_emit && res_base < 4'(dtfs_pkg::MaxResults);
      if (emit_ok)
        res_n <= res_base + 4'd1;
      else
        res_n <= res_base;

      if (end_step && pend_v) begin
        push     = 1'b1;
        push_ent = '{res: pend, last: 1'b1};
        pend_v   <= emit_ok;
        pend     <= new_res;
      end else if (emit_ok) begin
        if (pend_v) begin
          push     = 1'b1;
          push_ent = '{res: pend, last: 1'b0};
        end
        pend_v <= 1'b1;
        pend   <= new_res;
      end

      if (push) begin
        q[q_wr] <= push_ent;
        q_wr    <= !q_wr;
      end
      if (pop)
        q_rd <= !q_rd;
      q_cnt <= q_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    st.held_cnt <= 4'(dtfs_pkg::HoldDepth))
    else $error("pending byte count over depth");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt != 2'd3)
    else $error("output queue overflow");

  a_result_limit: assert property (@(posedge clk) disable iff (rst)
    res_n <= 4'(dtfs_pkg::MaxResults))
    else $error("result count over limit");

  a_pend_in_step: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> step_act)
    else $error("held result outside a transfer");

  a_mode_in_step: assert property (@(posedge clk) disable iff (rst)
    mode != M_RUN |-> step_act && !in_ready)
    else $error("sequencer busy outside a transfer");
`endif

endmodule

@@ src/dtfs_step.sv @@
// ----------------------------------------------------------------------------
// dtfs_step
// one parsing decision on the pending bytes: next state and at most one result
// ----------------------------------------------------------------------------
module dtfs_step (
  input  dtfs_pkg::cfg_t   cfg,
  input  dtfs_pkg::state_t st,
  output dtfs_pkg::state_t nxt,
  output logic             emit,
  output dtfs_pkg::res_t   res,
  output logic             seq_go,
  output logic             seq_delim
);

  logic [7:0]     h;
  logic           esc_hit;
  logic [1:0]     me;
  logic [1:0]     md;
  logic [3:0]     drop_n;
  logic           do_data;
  logic [7:0]     data_byte;
  logic           do_end;
  logic           end_row;
  logic           do_fail;
  dtfs_pkg::err_t fail_code;
  logic           skip_end;
  dtfs_pkg::err_t end_err;
  logic [11:0]    col_inc;
  logic [3:0]     src;

  always_comb begin
    h         = st.held[0];
    esc_hit   = cfg.escape_enable && h == cfg.escape_char;
    me        = dtfs_pkg::head_match(cfg, 1'b0, st);
    md        = dtfs_pkg::head_match(cfg, 1'b1, st);
    nxt       = st;
    emit      = 1'b0;
    res       = '0;
    seq_go    = 1'b0;
    seq_delim = 1'b0;
    drop_n    = 4'd0;
    do_data   = 1'b0;
    data_byte = 8'd0;
    do_end    = 1'b0;
    end_row   = 1'b0;
    do_fail   = 1'b0;
    fail_code = dtfs_pkg::ERR_NONE;
    skip_end  = 1'b0;
    end_err   = dtfs_pkg::ERR_NONE;
    col_inc   = {1'b0, st.col} + 12'd1;
    src       = 4'd0;

    if (st.held_cnt != 4'd0) begin
      if (st.phase == dtfs_pkg::PH_SKIP) begin
        if (me == dtfs_pkg::MATCH_FULL) begin
          drop_n   = dtfs_pkg::elen(cfg);
          skip_end = 1'b1;
        end else if (me == dtfs_pkg::MATCH_NONE) begin
          drop_n = 4'd1;
        end
      end else if (!cfg.quote_enable) begin
        nxt.phase = dtfs_pkg::PH_DATA;
        if (esc_hit) begin
          if (st.esc_par) begin
            do_data     = 1'b1;
            data_byte   = cfg.escape_char;
            nxt.esc_par = 1'b0;
          end else begin
            nxt.esc_par = 1'b1;
          end
          drop_n = 4'd1;
        end else if (me == dtfs_pkg::MATCH_FULL) begin
          drop_n = dtfs_pkg::elen(cfg);
          if (st.esc_par) begin
            seq_go      = 1'b1;
            nxt.esc_par = 1'b0;
          end else begin
            do_end  = 1'b1;
            end_row = 1'b1;
          end
        end else if (me == dtfs_pkg::MATCH_PREFIX || md == dtfs_pkg::MATCH_PREFIX) begin
          // wait for more bytes
        end else if (md == dtfs_pkg::MATCH_FULL) begin
          drop_n = dtfs_pkg::dlen(cfg);
          if (st.esc_par) begin
            seq_go      = 1'b1;
            seq_delim   = 1'b1;
            nxt.esc_par = 1'b0;
          end else begin
            do_end = 1'b1;
          end
        end else if (st.esc_par) begin
          do_data     = 1'b1;
          data_byte   = cfg.escape_char;
          nxt.esc_par = 1'b0;
        end else begin
          do_data   = 1'b1;
          data_byte = h;
          drop_n    = 4'd1;
        end
      end else if (st.phase == dtfs_pkg::PH_START) begin
        if (h == cfg.quote_char) begin
          drop_n    = 4'd1;
          nxt.phase = dtfs_pkg::PH_DATA;
        end else begin
          do_fail   = 1'b1;
          fail_code = dtfs_pkg::ERR_NO_QUOTE;
        end
      end else if (st.phase == dtfs_pkg::PH_DATA) begin
        if (st.esc_par) begin
          nxt.esc_par = 1'b0;
          if (h == cfg.escape_char || h == cfg.quote_char) begin
            do_data   = 1'b1;
            data_byte = h;
            drop_n    = 4'd1;
          end else if (cfg.escape_char == cfg.quote_char) begin
            nxt.phase = dtfs_pkg::PH_CLOSE;
          end else begin
            do_data   = 1'b1;
            data_byte = cfg.escape_char;
          end
        end else if (esc_hit) begin
          nxt.esc_par = 1'b1;
          drop_n      = 4'd1;
        end else if (h == cfg.quote_char) begin
          nxt.phase = dtfs_pkg::PH_CLOSE;
          drop_n    = 4'd1;
        end else begin
          do_data   = 1'b1;
          data_byte = h;
          drop_n    = 4'd1;
        end
      end else begin
        if (me == dtfs_pkg::MATCH_FULL) begin
          drop_n  = dtfs_pkg::elen(cfg);
          do_end  = 1'b1;
          end_row = 1'b1;
        end else if (me == dtfs_pkg::MATCH_PREFIX || md == dtfs_pkg::MATCH_PREFIX) begin
          // wait for more bytes
        end else if (md == dtfs_pkg::MATCH_FULL) begin
          drop_n = dtfs_pkg::dlen(cfg);
          do_end = 1'b1;
        end else if (cfg.escape_enable && cfg.escape_char == cfg.quote_char) begin
          // lone quote not followed by a separator is kept as data
          do_data   = 1'b1;
          data_byte = cfg.quote_char;
          nxt.phase = dtfs_pkg::PH_DATA;
        end else begin
          do_fail   = 1'b1;
          fail_code = dtfs_pkg::ERR_BARE_QUOTE;
        end
      end
    end

    // shift out consumed bytes
    for (int i = 0; i < dtfs_pkg::HoldDepth; i++) begin
      src = 4'(i) + drop_n;
      if (src < 4'(dtfs_pkg::HoldDepth))
        nxt.held[i] = st.held[src[2:0]];
    end
    nxt.held_cnt = st.held_cnt - drop_n;

    if (do_data) begin
      emit           = 1'b1;
      res.out_byte   = data_byte;
      res.byte_valid = 1'b1;
      res.field_index = st.col;
      nxt.has_data   = 1'b1;
    end

    if (skip_end) begin
      emit            = 1'b1;
      res.row_end     = 1'b1;
      res.field_index = st.col;
      nxt.col         = 11'd0;
      nxt.phase       = dtfs_pkg::PH_START;
      nxt.esc_par     = 1'b0;
      nxt.has_data    = 1'b0;
    end

    if (do_end) begin
      if (end_row && col_inc < {1'b0, dtfs_pkg::ncols(cfg)})
        end_err = dtfs_pkg::ERR_TOO_FEW;
      if (!end_row && col_inc >= {1'b0, dtfs_pkg::ncols(cfg)})
        end_err = dtfs_pkg::ERR_TOO_MANY;
      emit            = 1'b1;
      res.field_end   = 1'b1;
      res.field_null  = !st.has_data;
      res.field_index = st.col;
      res.row_end     = end_row;
      res.error_code  = end_err;
      nxt.has_data    = 1'b0;
      nxt.esc_par     = 1'b0;
      if (end_row) begin
        nxt.col   = 11'd0;
        nxt.phase = dtfs_pkg::PH_START;
      end else if (end_err != dtfs_pkg::ERR_NONE) begin
        nxt.phase = dtfs_pkg::PH_SKIP;
      end else begin
        nxt.col   = col_inc[10:0];
        nxt.phase = dtfs_pkg::PH_START;
      end
    end

    if (do_fail) begin
      emit            = 1'b1;
      res.field_end   = 1'b1;
      res.field_null  = !st.has_data;
      res.field_index = st.col;
      res.error_code  = fail_code;
      nxt.has_data    = 1'b0;
      nxt.esc_par     = 1'b0;
      nxt.phase       = dtfs_pkg::PH_SKIP;
    end
  end

endmodule
